[src/mmac_pkg.sv]
// Shared types and opcode constants for the memory-to-memory ALU core.
package mmac_pkg;

    typedef enum logic [4:0] {
        OP_NOP     = 5'd0,
        OP_LOADIMM = 5'd1,
        OP_MOV     = 5'd2,
        OP_ADD     = 5'd3,
        OP_SUB     = 5'd4,
        OP_MUL     = 5'd5,
        OP_DIV     = 5'd6,
        OP_MOD     = 5'd7,
        OP_AND     = 5'd8,
        OP_OR      = 5'd9,
        OP_NOT     = 5'd10,
        OP_XOR     = 5'd11,
        OP_SHR     = 5'd12,
        OP_SHL     = 5'd13,
        OP_EQ      = 5'd14,
        OP_GT      = 5'd15,
        OP_LT      = 5'd16,
        OP_SKIPIF  = 5'd17,
        OP_JUMP    = 5'd18,
        OP_OUTPUT  = 5'd19,
        OP_HALT    = 5'd20
    } opcode_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIVZ   = 2'd1;
    localparam logic [1:0] ST_HALTED = 2'd2;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [7:0]  dest_addr;
        logic [7:0]  src_addr;
        logic [15:0] immediate;
        logic [15:0] jump_line;
    } instr_t;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_READ,
        EX_OPER,
        EX_DIV,
        EX_FIX,
        EX_DONE
    } ex_state_t;

    // Instruction beat: opcode, dest, src, imm, jump -> 53 bits, padded to 56.
    localparam int IN_BITS  = 56;
    // Result beat: out_value, out_valid, next_line, status, halted -> 36, padded to 40.
    localparam int OUT_BITS = 40;

endpackage

[src/memory_to_memory_alu_core_unit.sv]
// Top level of the memory-to-memory ALU core: front queue plus execution back end.
//
//  channel  | signals                        | beat contents
//  ---------+--------------------------------+-----------------------------------------
//  s_axis   | s_axis_tvalid/tready/tdata[55:0] | one decoded instruction
//  m_axis   | m_axis_tvalid/tready/tdata[39:0] | one result per instruction
//
// Each instruction passes through the back end in order (take, read, operate, result);
// div and mod add the 16-step restoring divider and a fix-up step. The front queue holds
// two instructions so input beats are taken while the back end works or the result
// waits. Reset clears the line counter to 1 and the halt flag; memory is not cleared.
// A stalled result holds the back end; the queue fills, then s_axis_tready drops.
module memory_to_memory_alu_core_unit
    import mmac_pkg::*;
#(
    parameter int MEM_WORDS = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // opcode[4:0], dest_addr[12:5], src_addr[20:13], immediate[36:21], jump_line[52:37]
    input  logic [IN_BITS-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // out_value[15:0], out_valid[16], next_line[32:17], status[34:33], halted[35]
    output logic [OUT_BITS-1:0] m_axis_tdata
);

    logic   q_valid;
    logic   q_pop;
    instr_t q_instr;

    // Accept and hold instructions.
    mmac_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_instr  (q_instr)
    );

    // Execute them in order against the data memory.
    mmac_back #(
        .MEM_WORDS (MEM_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_instr   (q_instr),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (m_axis_tdata)
    );

endmodule

[src/mmac_front.sv]
// Instruction front end: accept beats, unpack and queue them for execution.
module mmac_front
    import mmac_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [IN_BITS-1:0]  in_data,
    output logic                q_valid,
    input  logic                q_pop,
    output instr_t              q_instr
);

    instr_t     slot_reg [2];
    logic [1:0] count_reg;
    logic       rd_reg;
    logic       wr_reg;
    instr_t     in_instr;
    logic       push;

    assign in_instr.opcode    = in_data[4:0];
    assign in_instr.dest_addr = in_data[12:5];
    assign in_instr.src_addr  = in_data[20:13];
    assign in_instr.immediate = in_data[36:21];
    assign in_instr.jump_line = in_data[52:37];

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_instr  = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_instr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

[src/mmac_back.sv]
// Execution back end: data memory, ALU, serial divider and line counter.
module mmac_back
    import mmac_pkg::*;
#(
    parameter int MEM_WORDS = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  instr_t              q_instr,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [OUT_BITS-1:0] res_data
);

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    // Address fold by reciprocal multiplication, exact for any 8-bit address.
    localparam int IDX_SH  = 8 + AW;
    localparam int IDX_MUL = ((1 << IDX_SH) + MEM_WORDS - 1) / MEM_WORDS;

    logic [15:0]  mem [MEM_WORDS];

    ex_state_t    state_reg, state_next;
    instr_t       ins_reg;
    logic [AW-1:0] da_reg, sa_reg;
    logic [15:0]  vd_reg, vs_reg;
    logic [15:0]  line_reg, line_next;
    logic         halt_reg;
    logic [15:0]  quo_reg, rem_reg;
    logic [4:0]   cnt_reg;
    logic [15:0]  mag_d, mag_s;
    logic [16:0]  trial;
    logic [15:0]  wval;
    logic         wen;
    logic [1:0]   st;
    logic [15:0]  outv;
    logic         outvalid;
    logic [15:0]  mul_lo;
    logic [15:0]  res_val_reg;
    logic         res_vld_reg;
    logic [15:0]  res_line_reg;
    logic [1:0]   res_st_reg;
    logic         res_halt_reg;
    logic         res_val_flag_reg;
    logic         out_free;
    logic [31:0]  mul_full;
    logic [15:0]  alu_val;

    function automatic logic [AW-1:0] cell_idx(input logic [7:0] a);
        logic [31:0] prod;
        logic [31:0] quo;
        logic [31:0] rem;
        prod = {24'd0, a} * 32'(IDX_MUL);
        quo  = prod >> IDX_SH;
        rem  = {24'd0, a} - quo * 32'(MEM_WORDS);
        return rem[AW-1:0];
    endfunction

    assign out_free = !res_vld_reg || res_ready;
    assign mag_d = vd_reg[15] ? (16'd0 - vd_reg) : vd_reg;
    assign mag_s = vs_reg[15] ? (16'd0 - vs_reg) : vs_reg;
    assign trial = {rem_reg, quo_reg[15]} - {1'b0, mag_s};
    assign mul_full = vd_reg * vs_reg;
    assign mul_lo = mul_full[15:0];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EX_IDLE: if (q_valid) state_next = EX_READ;
            EX_READ: state_next = EX_OPER;
            EX_OPER:
            begin
                if (!halt_reg && (ins_reg.opcode == OP_DIV || ins_reg.opcode == OP_MOD)
                    && vs_reg != 16'd0)
                    state_next = EX_DIV;
                else
                    state_next = EX_DONE;
            end
            EX_DIV:  if (cnt_reg == 5'd15) state_next = EX_FIX;
            EX_FIX:  state_next = EX_DONE;
            EX_DONE: if (out_free) state_next = EX_IDLE;
            default: state_next = EX_IDLE;
        endcase
    end

    // ALU result for the operations that do not use the divider.
    always_comb
    begin
        alu_val = 16'd0;
        case (ins_reg.opcode)
            OP_LOADIMM: alu_val = ins_reg.immediate;
            OP_MOV:     alu_val = vs_reg;
            OP_ADD:     alu_val = vd_reg + vs_reg;
            OP_SUB:     alu_val = vd_reg - vs_reg;
            OP_MUL:     alu_val = mul_lo;
            OP_AND:     alu_val = vd_reg & vs_reg;
            OP_OR:      alu_val = vd_reg | vs_reg;
            OP_NOT:     alu_val = ~vd_reg;
            OP_XOR:     alu_val = vd_reg ^ vs_reg;
            OP_SHR:     alu_val = (vs_reg >= 16'd16) ? {16{vd_reg[15]}}
                                  : 16'($signed(vd_reg) >>> vs_reg[3:0]);
            OP_SHL:     alu_val = (vs_reg >= 16'd16) ? 16'd0 : (vd_reg << vs_reg[3:0]);
            OP_EQ:      alu_val = {15'd0, vd_reg == vs_reg};
            OP_GT:      alu_val = {15'd0, $signed(vd_reg) > $signed(vs_reg)};
            OP_LT:      alu_val = {15'd0, $signed(vd_reg) < $signed(vs_reg)};
            default:    alu_val = 16'd0;
        endcase
    end

    // Output logic: memory write, line flow and status for the finishing item.
    always_comb
    begin
        wen       = 1'b0;
        wval      = alu_val;
        st        = ST_OK;
        outv      = 16'd0;
        outvalid  = 1'b0;
        line_next = line_reg + 16'd1;
        if (halt_reg)
        begin
            st        = ST_HALTED;
            line_next = line_reg;
        end
        else
        begin
            case (ins_reg.opcode) inside
                OP_LOADIMM, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_NOT,
                OP_XOR, OP_SHR, OP_SHL, OP_EQ, OP_GT, OP_LT:
                    wen = (state_reg == EX_OPER);
                OP_DIV, OP_MOD:
                begin
                    if (vs_reg == 16'd0)
                        st = ST_DIVZ;
                    wen  = (state_reg == EX_FIX);
                    if (ins_reg.opcode == OP_DIV)
                        wval = (vd_reg[15] ^ vs_reg[15]) ? (16'd0 - quo_reg) : quo_reg;
                    else
                        wval = vd_reg[15] ? (16'd0 - rem_reg) : rem_reg;
                end
                OP_SKIPIF: if (!vd_reg[0]) line_next = line_reg + 16'd2;
                OP_JUMP:   line_next = ins_reg.jump_line + 16'd1;
                OP_OUTPUT:
                begin
                    outv     = vd_reg;
                    outvalid = 1'b1;
                end
                OP_HALT:   line_next = line_reg;
                default:   ;
            endcase
        end
    end

    assign q_pop = (state_reg == EX_IDLE) && q_valid;

    // Memory and datapath registers: instruction latch, registered reads, one write port, divider.
    always_ff @(posedge clk)
    begin
        if (state_reg == EX_IDLE && q_valid)
        begin
            ins_reg <= q_instr;
            da_reg  <= cell_idx(q_instr.dest_addr);
            sa_reg  <= cell_idx(q_instr.src_addr);
        end
        if (state_reg == EX_READ)
        begin
            vd_reg <= mem[da_reg];
            vs_reg <= mem[sa_reg];
        end
        if (wen)
        begin
            mem[da_reg] <= wval;
        end
        if (state_reg == EX_OPER)
        begin
            quo_reg <= mag_d;
            rem_reg <= 16'd0;
        end
        else if (state_reg == EX_DIV)
        begin
            // Restoring step: one quotient bit a cycle.
            if (!trial[16])
                rem_reg <= trial[15:0];
            else
                rem_reg <= {rem_reg[14:0], quo_reg[15]};
            quo_reg <= {quo_reg[14:0], !trial[16]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= EX_IDLE;
            line_reg         <= 16'd1;
            halt_reg         <= 1'b0;
            cnt_reg          <= 5'd0;
            res_vld_reg      <= 1'b0;
            res_val_reg      <= 16'd0;
            res_line_reg     <= 16'd0;
            res_st_reg       <= ST_OK;
            res_halt_reg     <= 1'b0;
            res_val_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == EX_OPER)
                cnt_reg <= 5'd0;
            else if (state_reg == EX_DIV)
                cnt_reg <= cnt_reg + 5'd1;
            if (res_vld_reg && res_ready)
                res_vld_reg <= 1'b0;
            if (state_reg == EX_DONE && out_free)
            begin
                res_vld_reg      <= 1'b1;
                res_val_reg      <= outv;
                res_val_flag_reg <= outvalid;
                res_line_reg     <= line_next;
                res_st_reg       <= st;
                line_reg         <= line_next;
                if (!halt_reg && ins_reg.opcode == OP_HALT)
                    halt_reg <= 1'b1;
                res_halt_reg <= halt_reg || (ins_reg.opcode == OP_HALT);
            end
        end
    end

    assign res_valid = res_vld_reg;
    assign res_data  = {4'd0, res_halt_reg, res_st_reg, res_line_reg,
                        res_val_flag_reg, res_val_reg};

endmodule
